// ----- rtl/mrms_pkg.sv -----
// shared types, codes and constants of the masked register map store
// no dependencies; imported by mrms_cell and masked_register_map_store
package mrms_pkg;

    localparam int ENTRIES_DEF = 16;
    localparam int DATA_W      = 32;

    localparam logic [DATA_W-1:0] MISS_WORD = 32'hDEAD_BEEF;
    localparam logic [DATA_W-1:0] SIZE_RST  = 32'd4096;

    // request op codes
    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // response status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_OUTSIDE = 2'd1;
    localparam logic [1:0] ST_MISSING = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    // configuration register indexes
    localparam logic CFG_BASE = 1'b0;
    localparam logic CFG_SIZE = 1'b1;

    typedef struct packed {
        logic [1:0]        op;
        logic [DATA_W-1:0] address;
        logic [DATA_W-1:0] data_value;
        logic [DATA_W-1:0] write_mask;
    } t_req;

    typedef struct packed {
        logic [1:0]        status;
        logic [DATA_W-1:0] read_data;
    } t_rsp;

    // one stored register
    typedef struct packed {
        logic [DATA_W-1:0] address;
        logic [DATA_W-1:0] value;
        logic [DATA_W-1:0] mask;
    } t_entry;

    // lookup token walking the cell chain
    typedef struct packed {
        logic              live;
        logic [1:0]        op;
        logic [DATA_W-1:0] address;
        logic [DATA_W-1:0] data_value;
        logic              found;
        logic [DATA_W-1:0] read_data;
    } t_tok;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_HOLD = 3'b100
    } t_state;

endpackage

// ----- rtl/mrms_cell.sv -----
// one cell of the store: holds one entry and one stage of the lookup token
// depends on mrms_pkg
module mrms_cell (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic             i_shift,
    input  mrms_pkg::t_entry i_prev,
    input  mrms_pkg::t_tok   i_tok,
    output mrms_pkg::t_entry o_ent,
    output mrms_pkg::t_tok   o_tok
);
    import mrms_pkg::*;

    t_entry r_ent;
    t_tok   r_tok;
    t_tok   n_tok;
    logic   w_match;

    // first live cell from the newest end whose address matches claims the token
    assign w_match = i_tok.live && !i_tok.found && i_valid &&
                     (r_ent.address == i_tok.address);

    always_comb begin
        n_tok = i_tok;
        if (w_match) begin
            n_tok.found     = 1'b1;
            n_tok.read_data = r_ent.value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.live <= 1'b0;
        end else begin
            r_tok <= n_tok;
        end
    end

    // shift only happens while idle, writes only when a live write token matches
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_ent <= i_prev;
        end else if (w_match && i_tok.op == OP_WRITE) begin
            r_ent.value <= (i_tok.data_value & r_ent.mask) | (r_ent.value & ~r_ent.mask);
        end
    end

    assign o_ent = r_ent;
    assign o_tok = r_tok;

endmodule

// ----- rtl/masked_register_map_store.sv -----
// top level of the masked register map store: window check, control and result register
// depends on mrms_pkg and mrms_cell
//
// Usage:
//   Requests arrive on i_in_valid / o_in_ready with payload i_in_req (op, address,
//   data_value, write_mask). Each request gives exactly one response on
//   o_out_valid / i_out_ready with payload o_out_rsp (status, read_data).
//   Window registers are written through i_cfg_we / i_cfg_index / i_cfg_data
//   while no request is in flight; index 0 is window_base, 1 is window_size.
//   Entries live in a row of ENTRIES cells, newest in cell 0; an add shifts the
//   row by one cell. A write or read sends a lookup token down
//   the row, one cell per cycle; the first matching cell serves it.
//   Add and unused ops are answered from the window check straight into the output
//   register; write and read are answered when the token leaves the last cell.
//   Adds are taken at one request per cycle while the receiver keeps up; a write or
//   read blocks new requests until its token has walked through the whole cell row.
//   A new request is taken as soon as the previous one has its response in the
//   output register; when the receiver stalls, one finished response is parked
//   and no further request is taken until the output register frees up.
//   Reset empties the table (entry count zero), clears the handshakes and sets
//   the window to base 0, size 4096. No clearing pass is needed.
module masked_register_map_store #(
    parameter int ENTRIES = mrms_pkg::ENTRIES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  mrms_pkg::t_req                  i_in_req,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output mrms_pkg::t_rsp                  o_out_rsp,
    input  logic                            i_cfg_we,
    input  logic                            i_cfg_index,
    input  logic [mrms_pkg::DATA_W-1:0]     i_cfg_data
);
    import mrms_pkg::*;

    localparam int CW = $clog2(ENTRIES + 1);
    localparam logic [CW-1:0] FULL_C = CW'(ENTRIES);

    t_state            r_state, n_state;
    logic [CW-1:0]     r_count;
    logic [DATA_W-1:0] r_base, r_size;
    logic              r_out_valid;
    t_rsp              r_out, r_pend;

    logic              w_in_acc, w_out_free, w_scan_req, w_add_ok, w_res_ev;
    logic              w_outside, w_full;
    logic [DATA_W-1:0] w_limit;
    t_rsp              w_imm, w_scan_rsp, w_res;
    t_tok              w_inj;
    t_entry            w_new;
    t_tok              w_tok [ENTRIES];
    t_entry            w_ent [ENTRIES];
    logic [ENTRIES-1:0] w_live;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;

    // window limit wraps modulo 2^32
    assign w_limit   = r_base + r_size;
    assign w_outside = (i_in_req.address < r_base) || (i_in_req.address >= w_limit);
    assign w_full    = (r_count >= FULL_C);

    assign w_scan_req = w_in_acc && (i_in_req.op == OP_WRITE || i_in_req.op == OP_READ);
    assign w_add_ok   = w_in_acc && (i_in_req.op == OP_ADD) && !w_outside && !w_full;

    always_comb begin
        w_imm.read_data = '0;
        w_imm.status    = ST_OK;
        if (i_in_req.op == OP_ADD) begin
            if (w_outside) begin
                w_imm.status = ST_OUTSIDE;
            end else if (w_full) begin
                w_imm.status = ST_FULL;
            end
        end
    end

    always_comb begin
        w_inj.live       = w_scan_req;
        w_inj.op         = i_in_req.op;
        w_inj.address    = i_in_req.address;
        w_inj.data_value = i_in_req.data_value;
        w_inj.found      = 1'b0;
        w_inj.read_data  = '0;
    end

    assign w_new.address = i_in_req.address;
    assign w_new.value   = i_in_req.data_value;
    assign w_new.mask    = i_in_req.write_mask;

    genvar gi;
    generate
        for (gi = 0; gi < ENTRIES; gi++) begin : g_cell
            logic   w_cvalid;
            t_entry w_prev;
            t_tok   w_tin;
            assign w_cvalid = (r_count > CW'(gi));
            if (gi == 0) begin : g_head
                assign w_prev = w_new;
                assign w_tin  = w_inj;
            end else begin : g_body
                assign w_prev = w_ent[gi-1];
                assign w_tin  = w_tok[gi-1];
            end
            mrms_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_valid (w_cvalid),
                .i_shift (w_add_ok),
                .i_prev  (w_prev),
                .i_tok   (w_tin),
                .o_ent   (w_ent[gi]),
                .o_tok   (w_tok[gi])
            );
            assign w_live[gi] = w_tok[gi].live;
        end
    endgenerate

    // token leaving the last cell carries the lookup result
    always_comb begin
        w_scan_rsp.status    = ST_OK;
        w_scan_rsp.read_data = '0;
        if (w_tok[ENTRIES-1].found) begin
            if (w_tok[ENTRIES-1].op == OP_READ) begin
                w_scan_rsp.read_data = w_tok[ENTRIES-1].read_data;
            end
        end else begin
            w_scan_rsp.status = ST_MISSING;
            if (w_tok[ENTRIES-1].op == OP_READ) begin
                w_scan_rsp.read_data = MISS_WORD;
            end
        end
    end

    assign w_res_ev = (w_in_acc && !w_scan_req) ||
                      ((r_state == S_SCAN) && w_tok[ENTRIES-1].live);
    assign w_res    = (r_state == S_SCAN) ? w_scan_rsp : w_imm;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_scan_req) begin
                    n_state = S_SCAN;
                end else if (w_res_ev && !w_out_free) begin
                    n_state = S_HOLD;
                end
            end
            S_SCAN: begin
                if (w_res_ev) begin
                    n_state = w_out_free ? S_IDLE : S_HOLD;
                end
            end
            S_HOLD: begin
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_base      <= '0;
            r_size      <= SIZE_RST;
        end else begin
            r_state <= n_state;
            if (w_add_ok) begin
                r_count <= r_count + 1'b1;
            end
            if (w_res_ev && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_state == S_HOLD) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_BASE: r_base <= i_cfg_data;
                    CFG_SIZE: r_size <= i_cfg_data;
                    default:  ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_ev) begin
            if (w_out_free) begin
                r_out <= w_res;
            end else begin
                r_pend <= w_res;
            end
        end else if (r_state == S_HOLD && i_out_ready) begin
            r_out <= r_pend;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_C)
        else $error("entry count beyond table size");

    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_live))
        else $error("more than one lookup token in the cell row");

    a_token_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_live != '0) |-> (r_state == S_SCAN))
        else $error("lookup token alive outside a scan");

    a_add_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_add_ok |=> (r_count == $past(r_count) + 1'b1))
        else $error("accepted add did not grow the table");

    a_hold_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_HOLD) |-> r_out_valid)
        else $error("parked response without a waiting output");

endmodule

// ----- sim/masked_register_map_store_tb.sv -----
`timescale 1ns / 1ps
// testbench of masked_register_map_store: directed and random requests, responses checked
// against a behavioral model of the register table kept in the monitor
// depends on mrms_pkg and the rtl of masked_register_map_store
module masked_register_map_store_tb;
    import mrms_pkg::*;

    localparam int DEPTH = ENTRIES_DEF;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_ready;
    t_req              i_in_req;
    logic              o_out_valid;
    logic              i_out_ready;
    t_rsp              o_out_rsp;
    logic              i_cfg_we;
    logic              i_cfg_index;
    logic [DATA_W-1:0] i_cfg_data;

    masked_register_map_store #(
        .ENTRIES(DEPTH)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_req   (i_in_req),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_rsp  (o_out_rsp),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    // model of the register table and window
    logic [DATA_W-1:0] map_addr  [DEPTH];
    logic [DATA_W-1:0] map_value [DEPTH];
    logic [DATA_W-1:0] map_mask  [DEPTH];
    int                map_count;
    logic [DATA_W-1:0] model_base;
    logic [DATA_W-1:0] model_size;

    t_req              req_backlog [$];
    t_rsp              pending_rsp [$];
    logic [DATA_W-1:0] add_pool    [$];

    // window as last written, used to aim add addresses
    logic [DATA_W-1:0] win_base;
    logic [DATA_W-1:0] win_size;

    int   send_idle_pct;
    int   stall_pct;
    int   err_count;
    logic in_taken;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("Simulation FAILED");
        $finish;
    end

    // newest entry holding addr, -1 when absent
    function automatic int newest_match(logic [DATA_W-1:0] addr);
        int idx;
        idx = -1;
        for (int i = 0; i < map_count; i++)
            if (map_addr[i] == addr) idx = i;
        return idx;
    endfunction

    function automatic t_rsp apply_request(t_req rq);
        t_rsp              rsp;
        logic [DATA_W-1:0] limit;
        int                hit;
        rsp.status    = ST_OK;
        rsp.read_data = '0;
        case (rq.op)
            OP_ADD: begin
                // limit wraps modulo 2^32
                limit = model_base + model_size;
                if (rq.address < model_base || rq.address >= limit) begin
                    rsp.status = ST_OUTSIDE;
                end else if (map_count >= DEPTH) begin
                    rsp.status = ST_FULL;
                end else begin
                    map_addr[map_count]  = rq.address;
                    map_value[map_count] = rq.data_value;
                    map_mask[map_count]  = rq.write_mask;
                    map_count++;
                end
            end
            OP_WRITE: begin
                hit = newest_match(rq.address);
                if (hit < 0) begin
                    rsp.status = ST_MISSING;
                end else begin
                    map_value[hit] = (rq.data_value & map_mask[hit])
                                   | (map_value[hit] & ~map_mask[hit]);
                end
            end
            OP_READ: begin
                hit = newest_match(rq.address);
                if (hit < 0) begin
                    rsp.status    = ST_MISSING;
                    rsp.read_data = MISS_WORD;
                end else begin
                    rsp.read_data = map_value[hit];
                end
            end
            default: ;
        endcase
        return rsp;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_rsp want;
        if (!i_rst_n) begin
            in_taken   <= 1'b0;
            model_base = '0;
            model_size = SIZE_RST;
            map_count  = 0;
        end else begin
            in_taken <= i_in_valid && o_in_ready;
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_BASE) model_base = i_cfg_data;
                else model_size = i_cfg_data;
            end
            if (i_in_valid && o_in_ready)
                pending_rsp.push_back(apply_request(i_in_req));
            if (o_out_valid && i_out_ready) begin
                if (pending_rsp.size() == 0) begin
                    err_count++;
                    $display("%0t: response with no request waiting, got status %0d data %h",
                             $time, o_out_rsp.status, o_out_rsp.read_data);
                end else begin
                    want = pending_rsp.pop_front();
                    if (o_out_rsp.status !== want.status) begin
                        err_count++;
                        $display("%0t: status mismatch, expected %0d, got %0d",
                                 $time, want.status, o_out_rsp.status);
                    end
                    if (o_out_rsp.read_data !== want.read_data) begin
                        err_count++;
                        $display("%0t: read_data mismatch, expected %h, got %h",
                                 $time, want.read_data, o_out_rsp.read_data);
                    end
                end
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid  <= 1'b0;
            i_out_ready <= 1'b0;
        end else begin
            // hold the current request until it is taken
            if (!i_in_valid || in_taken) begin
                if (req_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    i_in_valid <= 1'b1;
                    i_in_req   <= req_backlog.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
            i_out_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    task automatic queue_req(input logic [1:0] op, input logic [DATA_W-1:0] addr,
                             input logic [DATA_W-1:0] data, input logic [DATA_W-1:0] mask);
        t_req rq;
        rq.op         = op;
        rq.address    = addr;
        rq.data_value = data;
        rq.write_mask = mask;
        req_backlog.push_back(rq);
        if (op == OP_ADD) add_pool.push_back(addr);
    endtask

    task automatic cfg_write(input logic idx, input logic [DATA_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        if (idx == CFG_BASE) win_base = value;
        else win_size = value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // wait until every request is answered, then let the lookup row run empty
    task automatic settle();
        do @(posedge i_clk);
        while (req_backlog.size() != 0 || i_in_valid || pending_rsp.size() != 0);
        repeat (DEPTH + 4) @(negedge i_clk);
    endtask

    task automatic queue_random(input int count);
        int                pick;
        logic [1:0]        op;
        logic [DATA_W-1:0] addr;
        logic [DATA_W-1:0] mask;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 10) op = OP_ADD;
            else if (pick < 50) op = OP_WRITE;
            else if (pick < 93) op = OP_READ;
            else op = OP_UNUSED;
            pick = $urandom_range(0, 99);
            if (op == OP_ADD) begin
                // some duplicates, mostly inside the window, a few anywhere
                if (add_pool.size() != 0 && pick < 25)
                    addr = add_pool[$urandom_range(0, add_pool.size() - 1)];
                else if (pick < 85 && win_size != 0)
                    addr = win_base + $urandom_range(0, win_size - 1);
                else
                    addr = $urandom;
            end else if (add_pool.size() != 0 && pick < 80) begin
                addr = add_pool[$urandom_range(0, add_pool.size() - 1)];
            end else begin
                addr = $urandom;
            end
            case ($urandom_range(0, 3))
                0:       mask = '0;
                1:       mask = '1;
                default: mask = $urandom;
            endcase
            queue_req(op, addr, $urandom, mask);
        end
    endtask

    task automatic random_phase(input int send_pct, input int ready_pct, input int count);
        send_idle_pct = send_pct;
        stall_pct     = ready_pct;
        queue_random(count);
        settle();
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_in_req      = '0;
        i_out_ready   = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = CFG_BASE;
        i_cfg_data    = '0;
        err_count     = 0;
        send_idle_pct = 0;
        stall_pct     = 0;
        win_base      = '0;
        win_size      = SIZE_RST;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // default window: edges, masked writes, misses, unused op, duplicate add
        queue_req(OP_ADD,    32'h0000_0000, 32'h1234_5678, 32'hFFFF_0000);
        queue_req(OP_ADD,    32'h0000_0FFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_req(OP_ADD,    32'h0000_1000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_req(OP_ADD,    32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000);
        queue_req(OP_READ,   32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        queue_req(OP_WRITE,  32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000);
        queue_req(OP_READ,   32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        queue_req(OP_WRITE,  32'h0000_0FFF, 32'h0000_0000, 32'hFFFF_FFFF);
        queue_req(OP_READ,   32'h0000_0FFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_req(OP_WRITE,  32'h0000_0055, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_req(OP_READ,   32'h0000_0055, 32'h0000_0000, 32'h0000_0000);
        queue_req(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_req(OP_ADD,    32'h0000_0000, 32'hA5A5_A5A5, 32'h0000_FFFF);
        queue_req(OP_WRITE,  32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF);
        queue_req(OP_READ,   32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        settle();

        // window whose end wraps past the top rejects every add
        cfg_write(CFG_BASE, 32'hFFFF_F000);
        cfg_write(CFG_SIZE, 32'h0000_2000);
        queue_req(OP_ADD, 32'hFFFF_F000, 32'h0000_0001, 32'hFFFF_FFFF);
        queue_req(OP_ADD, 32'h0000_0800, 32'h0000_0002, 32'hFFFF_FFFF);
        settle();

        // empty window at the top base
        cfg_write(CFG_BASE, 32'hFFFF_FFFF);
        cfg_write(CFG_SIZE, 32'h0000_0000);
        queue_req(OP_ADD, 32'hFFFF_FFFF, 32'h0000_0003, 32'hFFFF_FFFF);
        settle();

        // window ending just below the top address
        cfg_write(CFG_BASE, 32'hFFFF_0000);
        cfg_write(CFG_SIZE, 32'h0000_FFFF);
        queue_req(OP_ADD,  32'hFFFF_FFFE, 32'h5A5A_5A5A, 32'hF0F0_F0F0);
        queue_req(OP_ADD,  32'hFFFF_FFFF, 32'h0000_0004, 32'hFFFF_FFFF);
        queue_req(OP_ADD,  32'hFFFE_FFFF, 32'h0000_0005, 32'hFFFF_FFFF);
        queue_req(OP_READ, 32'hFFFF_FFFE, 32'h0000_0000, 32'h0000_0000);
        settle();

        cfg_write(CFG_BASE, 32'h0000_0000);
        cfg_write(CFG_SIZE, 32'hFFFF_FFFF);
        random_phase(0, 0, 225);

        cfg_write(CFG_BASE, 32'h8000_0000);
        cfg_write(CFG_SIZE, 32'h0000_0040);
        random_phase(74, 0, 225);

        cfg_write(CFG_BASE, $urandom_range(0, 32'hFFFE_FFFF));
        cfg_write(CFG_SIZE, $urandom_range(1, 32'h0001_0000));
        random_phase(0, 74, 225);

        cfg_write(CFG_BASE, 32'h0000_1000);
        cfg_write(CFG_SIZE, 32'h0000_1000);
        random_phase(27, 27, 225);

        if (err_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/mrms_pkg.sv
rtl/mrms_cell.sv
rtl/masked_register_map_store.sv
sim/masked_register_map_store_tb.sv
